// ===== hw/rtl/interval_timer_bank_top_defines.svh =====
// Assertion macros shared by the interval timer bank RTL.
`ifndef INTERVAL_TIMER_BANK_TOP_DEFINES_SVH
`define INTERVAL_TIMER_BANK_TOP_DEFINES_SVH

`ifndef SYNTH
// Checked on every rising clk edge outside reset.
`define ITB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising clk edge, reset cycles included.
`define ITB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ITB_ASSERT(lbl, prop, msg)
`define ITB_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hw/rtl/itb_pkg.sv =====
// Shared types and constants of the interval timer bank.
`default_nettype none
package itb_pkg;

  localparam int CMD_W  = 2;
  localparam int CH_W   = 2;
  localparam int OFF_W  = 6;
  localparam int DATA_W = 32;
  localparam int RD_W   = 24;
  localparam int IRQ_W  = 3;

  typedef logic [CMD_W-1:0]  cmd_t;
  typedef logic [CH_W-1:0]   chan_t;
  typedef logic [OFF_W-1:0]  offset_t;
  typedef logic [DATA_W-1:0] wdata_t;
  typedef logic [RD_W-1:0]   rdata_t;
  typedef logic [IRQ_W-1:0]  irq_t;

  localparam cmd_t CMD_TICK  = 2'd0;
  localparam cmd_t CMD_READ  = 2'd1;
  localparam cmd_t CMD_WRITE = 2'd2;

  localparam offset_t OFF_CONTROL  = 6'd0;
  localparam offset_t OFF_STATUS   = 6'd1;
  localparam offset_t OFF_CMP_A    = 6'd2;
  localparam offset_t OFF_CMP_B    = 6'd3;
  localparam offset_t OFF_INTERVAL = 6'd4;
  localparam offset_t OFF_DIVIDE   = 6'd8;
  localparam offset_t OFF_PULSE    = 6'd12;
  localparam offset_t OFF_WATCHDOG = 6'd16;
  localparam offset_t OFF_COUNT    = 6'd60;

  localparam int CTL_W  = 8;
  localparam int STS_W  = 4;
  localparam int MODE_W = 16;
  localparam int DIV_W  = 3;

  localparam int CTL_EN_BIT   = 7;
  localparam int CTL_RST_BIT  = 5;
  localparam int IM_IE_BIT    = 15;
  localparam int IM_ZC_BIT    = 0;
  localparam int STS_FLAG_BIT = 0;

  localparam logic [1:0] MODE_HOLD = 2'd3;
  localparam int WDT_CHANNEL = 2;

endpackage
`default_nettype wire

// ===== hw/rtl/itb_if.sv =====
// Request and result channel interfaces of the interval timer bank.
`default_nettype none
interface itb_in_if import itb_pkg::*; ();
  logic    valid;
  logic    ready;
  cmd_t    command;
  chan_t   channel;
  offset_t reg_offset;
  wdata_t  write_data;

  modport source (output valid, command, channel, reg_offset, write_data, input ready);
  modport sink   (input valid, command, channel, reg_offset, write_data, output ready);
endinterface

interface itb_out_if import itb_pkg::*; ();
  logic   valid;
  logic   ready;
  rdata_t read_data;
  irq_t   irq_lines;

  modport source (output valid, read_data, irq_lines, input ready);
  modport sink   (input valid, read_data, irq_lines, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/interval_timer_bank_top.sv =====
// A request accepted on in_if is held in the request register; its result is
// computed from that register and held in the result register for out_if.
// Throughput: one request per cycle while out_if.ready holds; the request
// register and the result register each move on while the next stage is free
// or being emptied. Between them lie an add and two compares per timer, and
// the register mux. Reset is synchronous and active low; it clears the timer
// state and the valid flags of both stages, but sets the compares to all ones.
`default_nettype none
`include "interval_timer_bank_top_defines.svh"
module interval_timer_bank_top import itb_pkg::*; #(
  parameter int NUM_TIMERS  = 3,
  parameter int COUNT_STEP  = 1,
  parameter int COUNT_WIDTH = 24
) (
  input  logic clk,
  input  logic rst_n,
  itb_in_if.sink    in_if,
  itb_out_if.source out_if
);

  localparam int STEP_W = 9;
  localparam int SUM_W  = COUNT_WIDTH + STEP_W;

  logic    req_valid_r;
  cmd_t    req_cmd_r;
  chan_t   req_ch_r;
  offset_t req_off_r;
  wdata_t  req_data_r;

  logic   out_valid_r;
  rdata_t out_read_data_r;
  irq_t   out_irq_r;

  logic adv;
  logic in_ready;

  logic [CTL_W-1:0]       control_r  [NUM_TIMERS];
  logic [CTL_W-1:0]       control_nxt[NUM_TIMERS];
  logic [STS_W-1:0]       status_r   [NUM_TIMERS];
  logic [STS_W-1:0]       status_nxt [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] cmpa_r     [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] cmpa_nxt   [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] cmpb_r     [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] cmpb_nxt   [NUM_TIMERS];
  logic [MODE_W-1:0]      imode_r    [NUM_TIMERS];
  logic [MODE_W-1:0]      imode_nxt  [NUM_TIMERS];
  logic [DIV_W-1:0]       divide_r   [NUM_TIMERS];
  logic [DIV_W-1:0]       divide_nxt [NUM_TIMERS];
  logic [MODE_W-1:0]      pmode_r    [NUM_TIMERS];
  logic [MODE_W-1:0]      pmode_nxt  [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] count_r    [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] count_nxt  [NUM_TIMERS];
  logic [NUM_TIMERS-1:0]  irq_pending_r;
  logic [NUM_TIMERS-1:0]  irq_pending_nxt;
  logic [MODE_W-1:0]      wdt_mode_r;
  logic [MODE_W-1:0]      wdt_mode_nxt;

  logic [COUNT_WIDTH-1:0] tick_cnt[NUM_TIMERS];
  logic [NUM_TIMERS-1:0]  tick_hit;

  rdata_t rd_nxt;
  irq_t   irq_lines_nxt;

  assign adv      = req_valid_r && (!out_valid_r || out_if.ready);
  assign in_ready = !req_valid_r || adv;

  assign in_if.ready      = in_ready;
  assign out_if.valid     = out_valid_r;
  assign out_if.read_data = out_read_data_r;
  assign out_if.irq_lines = out_irq_r;

  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_tick
    logic [SUM_W-1:0]       sum;
    logic [COUNT_WIDTH-1:0] cnt_step;
    logic [COUNT_WIDTH-1:0] cnt_run;
    logic                   hit;

    assign sum      = {{STEP_W{1'b0}}, count_r[g]} + SUM_W'(COUNT_STEP);
    assign cnt_step = (|sum[SUM_W-1:COUNT_WIDTH]) ? '1 : sum[COUNT_WIDTH-1:0];
    assign cnt_run  = (control_r[g][CTL_EN_BIT] && (count_r[g] < cmpa_r[g])) ?
                      cnt_step : count_r[g];
    assign hit      = cnt_run >= cmpa_r[g];
    assign tick_cnt[g] = (hit && imode_r[g][IM_ZC_BIT]) ? '0 : cnt_run;
    assign tick_hit[g] = hit;
  end

  always_comb begin
    control_nxt     = control_r;
    status_nxt      = status_r;
    cmpa_nxt        = cmpa_r;
    cmpb_nxt        = cmpb_r;
    imode_nxt       = imode_r;
    divide_nxt      = divide_r;
    pmode_nxt       = pmode_r;
    count_nxt       = count_r;
    irq_pending_nxt = irq_pending_r;
    wdt_mode_nxt    = wdt_mode_r;
    rd_nxt          = '0;
    irq_lines_nxt   = '0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (req_ch_r == CH_W'(i)) begin
        case (req_cmd_r)
          CMD_TICK: begin
            if (adv && (control_r[i][1:0] != MODE_HOLD)) begin
              count_nxt[i] = tick_cnt[i];
              if (tick_hit[i]) begin
                if (imode_r[i][IM_IE_BIT]) begin
                  irq_pending_nxt[i] = 1'b1;
                end
                status_nxt[i][STS_FLAG_BIT] = 1'b1;
              end
            end
          end
          CMD_READ: begin
            case (req_off_r)
              OFF_CONTROL:  rd_nxt = RD_W'(control_r[i]);
              OFF_STATUS:   rd_nxt = RD_W'(status_r[i]);
              OFF_CMP_A:    rd_nxt = RD_W'(cmpa_r[i]);
              OFF_CMP_B:    rd_nxt = RD_W'(cmpb_r[i]);
              OFF_INTERVAL: rd_nxt = RD_W'(imode_r[i]);
              OFF_DIVIDE:   rd_nxt = RD_W'(divide_r[i]);
              OFF_PULSE:    rd_nxt = RD_W'(pmode_r[i]);
              OFF_WATCHDOG: rd_nxt = (i == WDT_CHANNEL) ? RD_W'(wdt_mode_r) : '0;
              OFF_COUNT:    rd_nxt = RD_W'(count_r[i]);
              default:      rd_nxt = '0;
            endcase
          end
          CMD_WRITE: begin
            if (adv) begin
              case (req_off_r)
                OFF_CONTROL: begin
                  control_nxt[i] = req_data_r[CTL_W-1:0];
                  if (!req_data_r[CTL_EN_BIT] && req_data_r[CTL_RST_BIT]) begin
                    count_nxt[i] = '0;
                  end
                end
                OFF_STATUS: begin
                  status_nxt[i][STS_W-1:1] = req_data_r[STS_W-1:1];
                  if (!req_data_r[STS_FLAG_BIT]) begin
                    status_nxt[i][STS_FLAG_BIT] = 1'b0;
                    irq_pending_nxt[i] = 1'b0;
                  end
                end
                OFF_CMP_A:    cmpa_nxt[i]   = req_data_r[COUNT_WIDTH-1:0];
                OFF_CMP_B:    cmpb_nxt[i]   = req_data_r[COUNT_WIDTH-1:0];
                OFF_INTERVAL: imode_nxt[i]  = req_data_r[MODE_W-1:0];
                OFF_DIVIDE:   divide_nxt[i] = req_data_r[DIV_W-1:0];
                OFF_PULSE:    pmode_nxt[i]  = req_data_r[MODE_W-1:0];
                OFF_WATCHDOG: begin
                  if (i == WDT_CHANNEL) begin
                    wdt_mode_nxt = req_data_r[MODE_W-1:0];
                  end
                end
                default: ;
              endcase
            end
          end
          default: ;
        endcase
      end
    end
    for (int i = 0; i < NUM_TIMERS && i < IRQ_W; i++) begin
      irq_lines_nxt[i] = irq_pending_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r   <= 1'b0;
      out_valid_r   <= 1'b0;
      irq_pending_r <= '0;
      wdt_mode_r    <= '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        control_r[i] <= '0;
        status_r[i]  <= '0;
        cmpa_r[i]    <= '1;
        cmpb_r[i]    <= '1;
        imode_r[i]   <= '0;
        divide_r[i]  <= '0;
        pmode_r[i]   <= '0;
        count_r[i]   <= '0;
      end
    end else begin
      if (in_ready) begin
        req_valid_r <= in_if.valid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      irq_pending_r <= irq_pending_nxt;
      wdt_mode_r    <= wdt_mode_nxt;
      control_r     <= control_nxt;
      status_r      <= status_nxt;
      cmpa_r        <= cmpa_nxt;
      cmpb_r        <= cmpb_nxt;
      imode_r       <= imode_nxt;
      divide_r      <= divide_nxt;
      pmode_r       <= pmode_nxt;
      count_r       <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      req_cmd_r  <= in_if.command;
      req_ch_r   <= in_if.channel;
      req_off_r  <= in_if.reg_offset;
      req_data_r <= in_if.write_data;
    end
    if (adv) begin
      out_read_data_r <= rd_nxt;
      out_irq_r       <= irq_lines_nxt;
    end
  end

  `ITB_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_valid_r && !req_valid_r, "reset left a request or result valid")
  `ITB_ASSERT(a_adv_fills, adv |=> out_valid_r, "advanced request produced no result")
  `ITB_ASSERT(a_nonread_zero, adv && req_cmd_r != CMD_READ |=> out_read_data_r == '0, "read data nonzero for a non-read request")
  `ITB_ASSERT(a_irq_by_tick, $rose(irq_pending_r[0]) |-> $past(adv && req_cmd_r == CMD_TICK), "interrupt raised without a tick")
  `ITB_ASSERT(a_irq_has_flag, irq_pending_r[0] |-> status_r[0][STS_FLAG_BIT], "pending interrupt without status flag")

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench of the interval timer bank: directed and random bus requests.
`default_nettype none
module tb import itb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_TIMERS = 3;
  localparam int COUNT_STEP = 1;
  localparam int COUNT_WIDTH = 24;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam int WATCHDOG_LIMIT = 500;
  localparam int DRAIN_CYCLES = 10;
  localparam int MAX_REPORTS = 10;
  localparam cmd_t CMD_UNUSED = 2'd3;
  localparam chan_t CH_ABSENT = 2'd3;
  localparam offset_t REG_OFFSETS [9] = '{OFF_CONTROL, OFF_STATUS, OFF_CMP_A, OFF_CMP_B,
    OFF_INTERVAL, OFF_DIVIDE, OFF_PULSE, OFF_WATCHDOG, OFF_COUNT};

  typedef struct packed {
    rdata_t read_data;
    irq_t   irq_lines;
  } timer_response_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  itb_in_if  in_if ();
  itb_out_if out_if ();

  interval_timer_bank_top #(
    .NUM_TIMERS (NUM_TIMERS),
    .COUNT_STEP (COUNT_STEP),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .out_if(out_if)
  );

  always #1 clk = ~clk;

  logic [CTL_W-1:0]       tmr_ctl      [NUM_TIMERS];
  logic [STS_W-1:0]       tmr_sts      [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] tmr_cmp_a    [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] tmr_cmp_b    [NUM_TIMERS];
  logic [MODE_W-1:0]      tmr_interval [NUM_TIMERS];
  logic [DIV_W-1:0]       tmr_divide   [NUM_TIMERS];
  logic [MODE_W-1:0]      tmr_pulse    [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] tmr_count    [NUM_TIMERS];
  logic                   tmr_irq      [NUM_TIMERS];
  logic [MODE_W-1:0]      wdt_mode;

  timer_response_t pending_responses [$];
  int unsigned requests_sent = 0;
  int unsigned failures = 0;
  int unsigned responses_seen = 0;
  int unsigned quiet_cycles = 0;
  bit no_idle = 1'b0;

  function automatic int unsigned idle_gap();
    return no_idle ? 0 : $urandom_range(0, 19);
  endfunction

  task automatic advance_timers(input cmd_t cmd, input chan_t ch, input offset_t off,
                                input wdata_t data, output timer_response_t resp);
    logic [32:0] nxt;
    resp = '0;
    if (ch < NUM_TIMERS) begin
      case (cmd)
        CMD_TICK: begin
          if (tmr_ctl[ch][1:0] != MODE_HOLD) begin
            if (tmr_ctl[ch][CTL_EN_BIT] && tmr_count[ch] < tmr_cmp_a[ch]) begin
              nxt = {9'd0, tmr_count[ch]} + 33'(COUNT_STEP);
              if (nxt > {9'd0, CNT_MAX}) nxt = {9'd0, CNT_MAX};
              tmr_count[ch] = nxt[COUNT_WIDTH-1:0];
            end
            if (tmr_count[ch] >= tmr_cmp_a[ch]) begin
              if (tmr_interval[ch][IM_ZC_BIT]) tmr_count[ch] = '0;
              if (tmr_interval[ch][IM_IE_BIT]) tmr_irq[ch] = 1'b1;
              tmr_sts[ch][STS_FLAG_BIT] = 1'b1;
            end
          end
        end
        CMD_READ: begin
          case (off)
            OFF_CONTROL:  resp.read_data = rdata_t'(tmr_ctl[ch]);
            OFF_STATUS:   resp.read_data = rdata_t'(tmr_sts[ch]);
            OFF_CMP_A:    resp.read_data = rdata_t'(tmr_cmp_a[ch]);
            OFF_CMP_B:    resp.read_data = rdata_t'(tmr_cmp_b[ch]);
            OFF_INTERVAL: resp.read_data = rdata_t'(tmr_interval[ch]);
            OFF_DIVIDE:   resp.read_data = rdata_t'(tmr_divide[ch]);
            OFF_PULSE:    resp.read_data = rdata_t'(tmr_pulse[ch]);
            OFF_WATCHDOG: resp.read_data = (ch == WDT_CHANNEL) ? rdata_t'(wdt_mode) : '0;
            OFF_COUNT:    resp.read_data = rdata_t'(tmr_count[ch]);
            default:      resp.read_data = '0;
          endcase
        end
        CMD_WRITE: begin
          case (off)
            OFF_CONTROL: begin
              tmr_ctl[ch] = data[CTL_W-1:0];
              if (!data[CTL_EN_BIT] && data[CTL_RST_BIT]) tmr_count[ch] = '0;
            end
            OFF_STATUS: begin
              if (data[STS_FLAG_BIT]) begin
                tmr_sts[ch] = {data[3:1], tmr_sts[ch][STS_FLAG_BIT]};
              end else begin
                tmr_sts[ch] = {data[3:1], 1'b0};
                tmr_irq[ch] = 1'b0;
              end
            end
            OFF_CMP_A:    tmr_cmp_a[ch] = data[COUNT_WIDTH-1:0];
            OFF_CMP_B:    tmr_cmp_b[ch] = data[COUNT_WIDTH-1:0];
            OFF_INTERVAL: tmr_interval[ch] = data[MODE_W-1:0];
            OFF_DIVIDE:   tmr_divide[ch] = data[DIV_W-1:0];
            OFF_PULSE:    tmr_pulse[ch] = data[MODE_W-1:0];
            OFF_WATCHDOG: if (ch == WDT_CHANNEL) wdt_mode = data[MODE_W-1:0];
            default: ;
          endcase
        end
        default: ;
      endcase
    end
    for (int i = 0; i < NUM_TIMERS && i < IRQ_W; i++) resp.irq_lines[i] = tmr_irq[i];
  endtask

  task automatic issue_request(input cmd_t cmd, input chan_t ch, input offset_t off,
                               input wdata_t data);
    int unsigned gap;
    timer_response_t resp;
    gap = idle_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.command    <= cmd;
    in_if.channel    <= ch;
    in_if.reg_offset <= off;
    in_if.write_data <= data;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    advance_timers(cmd, ch, off, data, resp);
    pending_responses.push_back(resp);
    requests_sent++;
  endtask

  task automatic test_reset_state();
    issue_request(CMD_READ, 2'd0, OFF_CMP_A, 32'h0);
    issue_request(CMD_READ, 2'd1, OFF_COUNT, 32'hffff_ffff);
    issue_request(CMD_READ, 2'd2, OFF_CMP_B, 32'h0);
    issue_request(CMD_READ, 2'd0, OFF_STATUS, 32'h0);
  endtask

  task automatic test_register_masks();
    issue_request(CMD_WRITE, 2'd0, OFF_CONTROL, 32'hffff_ffff);
    issue_request(CMD_READ, 2'd0, OFF_CONTROL, 32'h0);
    issue_request(CMD_WRITE, 2'd1, OFF_INTERVAL, 32'hffff_ffff);
    issue_request(CMD_WRITE, 2'd2, OFF_WATCHDOG, 32'hffff_ffff);
    issue_request(CMD_READ, 2'd2, OFF_WATCHDOG, 32'h0);
    issue_request(CMD_READ, 2'd1, OFF_WATCHDOG, 32'h0);
    issue_request(CMD_WRITE, 2'd2, OFF_DIVIDE, 32'hffff_ffff);
    issue_request(CMD_READ, 2'd2, OFF_DIVIDE, 32'h0);
  endtask

  task automatic test_mode_hold();
    issue_request(CMD_TICK, 2'd0, OFF_CONTROL, 32'h0);
    issue_request(CMD_READ, 2'd0, OFF_COUNT, 32'h0);
  endtask

  task automatic test_interval_irq();
    issue_request(CMD_WRITE, 2'd1, OFF_CMP_A, 32'h0000_0002);
    issue_request(CMD_WRITE, 2'd1, OFF_CONTROL, 32'h0000_0080);
    issue_request(CMD_TICK, 2'd1, OFF_CONTROL, 32'h0);
    issue_request(CMD_TICK, 2'd1, OFF_CONTROL, 32'h0);
    issue_request(CMD_WRITE, 2'd1, OFF_STATUS, 32'hffff_ffff);
    issue_request(CMD_READ, 2'd1, OFF_STATUS, 32'h0);
    issue_request(CMD_WRITE, 2'd1, OFF_STATUS, 32'h0000_0000);
  endtask

  task automatic test_counter_reset();
    issue_request(CMD_TICK, 2'd1, OFF_CONTROL, 32'h0);
    issue_request(CMD_WRITE, 2'd1, OFF_CONTROL, 32'h0000_0020);
    issue_request(CMD_READ, 2'd1, OFF_COUNT, 32'h0);
  endtask

  task automatic test_absent_channel();
    issue_request(CMD_WRITE, CH_ABSENT, OFF_CONTROL, 32'hffff_ffff);
    issue_request(CMD_READ, CH_ABSENT, OFF_CONTROL, 32'h0);
    issue_request(CMD_TICK, CH_ABSENT, OFF_CONTROL, 32'h0);
    issue_request(CMD_UNUSED, 2'd0, OFF_CONTROL, 32'hffff_ffff);
  endtask

  task automatic send_noise();
    offset_t off;
    off = $urandom_range(0, 1) ? REG_OFFSETS[$urandom_range(0, 8)]
                               : offset_t'($urandom_range(0, 63));
    issue_request(cmd_t'($urandom_range(0, 3)), chan_t'($urandom_range(0, 3)), off,
                  $urandom);
  endtask

  // Each sequence sets up one channel (now and then the absent one) to count toward
  // an interval, mostly a short one, and then ticks it, with reads, status writes and stray requests mixed in.
  task automatic test_timer_sequences(input int unsigned budget);
    int unsigned start;
    chan_t ch;
    wdata_t ctl;
    wdata_t sts;
    start = requests_sent;
    while (requests_sent - start < budget) begin
      no_idle = ($urandom_range(0, 3) == 0);
      ch = ($urandom_range(0, 15) == 0) ? CH_ABSENT : chan_t'($urandom_range(0, NUM_TIMERS - 1));
      issue_request(CMD_WRITE, ch, OFF_CMP_A,
                    ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 12));
      issue_request(CMD_WRITE, ch, OFF_INTERVAL, $urandom);
      ctl = $urandom;
      ctl[CTL_EN_BIT] = ($urandom_range(0, 7) != 0);
      if (ctl[1:0] == MODE_HOLD && $urandom_range(0, 3) != 0) ctl[1:0] = 2'($urandom_range(0, 2));
      issue_request(CMD_WRITE, ch, OFF_CONTROL, ctl);
      repeat ($urandom_range(1, 30)) begin
        case ($urandom_range(0, 9))
          0: issue_request(CMD_READ, ch, REG_OFFSETS[$urandom_range(0, 8)], $urandom);
          1: issue_request(CMD_READ, ch, $urandom_range(0, 1) ? OFF_COUNT : OFF_STATUS,
                           $urandom);
          2: begin
            sts = $urandom;
            issue_request(CMD_WRITE, ch, OFF_STATUS, sts);
          end
          3: send_noise();
          default: issue_request(CMD_TICK, ch, offset_t'($urandom_range(0, 63)), $urandom);
        endcase
      end
      if ($urandom_range(0, 2) == 0) begin
        ctl = $urandom;
        ctl[CTL_EN_BIT] = 1'b0;
        ctl[CTL_RST_BIT] = 1'b1;
        issue_request(CMD_WRITE, ch, OFF_CONTROL, ctl);
      end
    end
  endtask

  task automatic test_bus_noise(input int unsigned budget);
    repeat (budget) begin
      if ($urandom_range(0, 31) == 0) no_idle = ~no_idle;
      send_noise();
    end
  endtask

  initial begin
    timer_response_t want;
    int unsigned stall;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = idle_gap();
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!(out_if.valid && out_if.ready)) @(posedge clk);
      responses_seen++;
      if (pending_responses.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("response %0d arrived with no request outstanding: read_data %h irq %b",
                   responses_seen, out_if.read_data, out_if.irq_lines);
      end else begin
        want = pending_responses.pop_front();
        if (out_if.read_data !== want.read_data || out_if.irq_lines !== want.irq_lines) begin
          failures++;
          if (failures <= MAX_REPORTS)
            $display("response %0d: read_data exp %h got %h, irq_lines exp %b got %b",
                     responses_seen, want.read_data, out_if.read_data,
                     want.irq_lines, out_if.irq_lines);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_if.valid      <= 1'b0;
    in_if.command    <= CMD_TICK;
    in_if.channel    <= '0;
    in_if.reg_offset <= OFF_CONTROL;
    in_if.write_data <= '0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      tmr_ctl[i]      = '0;
      tmr_sts[i]      = '0;
      tmr_cmp_a[i]    = CNT_MAX;
      tmr_cmp_b[i]    = CNT_MAX;
      tmr_interval[i] = '0;
      tmr_divide[i]   = '0;
      tmr_pulse[i]    = '0;
      tmr_count[i]    = '0;
      tmr_irq[i]      = 1'b0;
    end
    wdt_mode = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_register_masks();
    test_mode_hold();
    test_interval_irq();
    test_counter_reset();
    test_absent_channel();
    test_timer_sequences(1250);
    test_bus_noise(275);
    in_if.valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== interval_timer_bank_top.f =====
+incdir+hw/rtl
hw/rtl/itb_pkg.sv
hw/rtl/itb_if.sv
hw/rtl/interval_timer_bank_top.sv
tb/tb.sv
